### hw/rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared constants, codes and helper function of the reply receiver.
// ----------------------------------------------------------------------------
package rsp_pkg;

    // Default width of the payload byte counter.
    localparam int DEF_COUNT_WIDTH = 12;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_RETRY_LIMIT  = 2'd0;
    localparam t_reg_idx REG_DECODE_HEX   = 2'd1;
    localparam t_reg_idx REG_DECODE_LIMIT = 2'd2;

    localparam logic [2:0] RETRY_LIMIT_RST = 3'd5;

    // Event codes of a result word.
    typedef logic [2:0] t_event;
    localparam t_event EV_DATA      = 3'd0;
    localparam t_event EV_RESEND    = 3'd1;
    localparam t_event EV_OK        = 3'd2;
    localparam t_event EV_ERR_REPLY = 3'd3;
    localparam t_event EV_BAD_SUM   = 3'd4;
    localparam t_event EV_ACK_MISS  = 3'd5;
    localparam t_event EV_BAD_HEX   = 3'd6;
    localparam t_event EV_ODD_HEX   = 3'd7;

    // Link characters.
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_ERR    = 8'h45;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    // ASCII hex digit to nibble; ok is low for a non-hex character.
    function automatic t_hex hex_val(input logic [7:0] b);
        t_hex r;
        r.ok  = 1'b1;
        r.nib = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.nib = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r.nib = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r.nib = 4'(b - 8'h37);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

### hw/rtl/rsp_if.sv
// ----------------------------------------------------------------------------
// rsp_in_if / rsp_out_if
// Valid/ready channels for link words in and reply events out.
// ----------------------------------------------------------------------------
interface rsp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface rsp_out_if #(
    parameter int COUNT_WIDTH = rsp_pkg::DEF_COUNT_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [2:0]             event_res;
    logic [7:0]             data_byte;
    logic                   send_ack;
    logic [COUNT_WIDTH-1:0] byte_count;
    logic                   last;

    modport source (output valid, output event_res, output data_byte, output send_ack,
                    output byte_count, output last, input ready);
    modport sink   (input valid, input event_res, input data_byte, input send_ack,
                    input byte_count, input last, output ready);
endinterface

### hw/rtl/rsp_apb_regs.sv
// ----------------------------------------------------------------------------
// rsp_apb_regs
// APB configuration registers: retry limit, hex decode enable, decode limit.
// ----------------------------------------------------------------------------
module rsp_apb_regs #(
    parameter int COUNT_WIDTH = rsp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rsp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rsp_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output logic [2:0]                    o_retry_limit,
    output logic                          o_decode_hex,
    output logic [COUNT_WIDTH-1:0]        o_decode_limit
);

    logic [2:0]             r_retry_limit;
    logic                   r_decode_hex;
    logic [COUNT_WIDTH-1:0] r_decode_limit;
    rsp_pkg::t_reg_idx      idx;
    logic                   wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit  <= rsp_pkg::RETRY_LIMIT_RST;
            r_decode_hex   <= 1'b0;
            r_decode_limit <= '1;
        end else if (wr_en) begin
            unique case (idx)
                rsp_pkg::REG_RETRY_LIMIT:  r_retry_limit  <= pwdata[2:0];
                rsp_pkg::REG_DECODE_HEX:   r_decode_hex   <= pwdata[0];
                rsp_pkg::REG_DECODE_LIMIT: r_decode_limit <= pwdata[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            rsp_pkg::REG_RETRY_LIMIT:  prdata = 32'(r_retry_limit);
            rsp_pkg::REG_DECODE_HEX:   prdata = 32'(r_decode_hex);
            rsp_pkg::REG_DECODE_LIMIT: prdata = 32'(r_decode_limit);
            default:                   prdata = '0;
        endcase
    end

    assign o_retry_limit  = r_retry_limit;
    assign o_decode_hex   = r_decode_hex;
    assign o_decode_limit = r_decode_limit;

endmodule

### hw/rtl/rsp_core.sv
// ----------------------------------------------------------------------------
// rsp_core
// Packet parser: input register, one pass of exchange state update, result
// register.
// ----------------------------------------------------------------------------
module rsp_core #(
    parameter int COUNT_WIDTH = rsp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [2:0]             i_retry_limit,
    input  logic                   i_decode_hex,
    input  logic [COUNT_WIDTH-1:0] i_decode_limit,
    rsp_in_if.sink                 i_in,
    rsp_out_if.source              o_out
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ACK   = 3'd1;
    localparam logic [2:0] PH_SCAN  = 3'd2;
    localparam logic [2:0] PH_BODY  = 3'd3;
    localparam logic [2:0] PH_SUMHI = 3'd4;
    localparam logic [2:0] PH_SUMLO = 3'd5;

    // Input register.
    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_byte;

    // Exchange state.
    logic [2:0]             r_phase, n_phase;
    logic [2:0]             r_retries, n_retries;
    logic [7:0]             r_sum, n_sum;
    logic [3:0]             r_sum_hi, n_sum_hi;
    logic                   r_sum_bad, n_sum_bad;
    logic [3:0]             r_nib, n_nib;
    logic                   r_half, n_half;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_first, n_first;
    logic                   r_err, n_err;
    logic                   r_bad_hex, n_bad_hex;
    logic                   r_skip, n_skip;

    // Result register.
    logic                   r_out_valid;
    logic [2:0]             r_ev;
    logic [7:0]             r_data;
    logic                   r_ack;
    logic [COUNT_WIDTH-1:0] r_cnt_out;
    logic                   r_last;

    logic                   res_valid;
    rsp_pkg::t_event        res_ev;
    logic [7:0]             res_data;
    logic                   res_ack;
    logic [COUNT_WIDTH-1:0] res_cnt;
    logic                   res_last;

    logic         advance;
    logic         step;
    rsp_pkg::t_hex hx;
    logic         err_now;
    logic         good;

    assign advance = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign step = r_in_valid && advance;
    assign hx = rsp_pkg::hex_val(r_byte);

    always_comb begin
        n_phase   = r_phase;
        n_retries = r_retries;
        n_sum     = r_sum;
        n_sum_hi  = r_sum_hi;
        n_sum_bad = r_sum_bad;
        n_nib     = r_nib;
        n_half    = r_half;
        n_count   = r_count;
        n_first   = r_first;
        n_err     = r_err;
        n_bad_hex = r_bad_hex;
        n_skip    = r_skip;
        res_valid = 1'b0;
        res_ev    = rsp_pkg::EV_DATA;
        res_data  = 8'd0;
        res_ack   = 1'b0;
        res_cnt   = '0;
        res_last  = 1'b0;
        err_now   = r_err || (!r_first && r_byte == rsp_pkg::CH_ERR);
        good      = !r_sum_bad && hx.ok && ({r_sum_hi, hx.nib} == r_sum);

        if (!r_kind) begin
            // A new command drops whatever exchange was in flight.
            n_phase   = PH_ACK;
            n_retries = i_retry_limit;
            n_sum     = '0;
            n_sum_hi  = '0;
            n_sum_bad = 1'b0;
            n_nib     = '0;
            n_half    = 1'b0;
            n_count   = '0;
            n_first   = 1'b0;
            n_err     = 1'b0;
            n_bad_hex = 1'b0;
            n_skip    = 1'b0;
        end else begin
            unique case (r_phase)
                PH_ACK: begin
                    if (r_byte == rsp_pkg::CH_PLUS) begin
                        n_phase   = PH_SCAN;
                        n_sum     = '0;
                        n_sum_hi  = '0;
                        n_sum_bad = 1'b0;
                        n_nib     = '0;
                        n_half    = 1'b0;
                        n_count   = '0;
                        n_first   = 1'b0;
                        n_err     = 1'b0;
                        n_bad_hex = 1'b0;
                        n_skip    = 1'b0;
                    end else if (r_byte == rsp_pkg::CH_MINUS && r_retries != 3'd0) begin
                        n_retries = r_retries - 3'd1;
                        res_valid = 1'b1;
                        res_ev    = rsp_pkg::EV_RESEND;
                    end else begin
                        n_phase   = PH_IDLE;
                        res_valid = 1'b1;
                        res_ev    = rsp_pkg::EV_ACK_MISS;
                        res_last  = 1'b1;
                    end
                end
                PH_SCAN: begin
                    if (r_byte == rsp_pkg::CH_DOLLAR) begin
                        n_phase = PH_BODY;
                    end else begin
                        n_skip = 1'b1;
                    end
                end
                PH_BODY: begin
                    if (r_byte == rsp_pkg::CH_HASH) begin
                        n_phase = PH_SUMHI;
                    end else begin
                        n_sum   = r_sum + r_byte;
                        n_first = 1'b1;
                        n_err   = err_now;
                        if (!i_decode_hex || err_now) begin
                            // Raw payload: the count saturates.
                            if (r_count != '1) begin
                                n_count = r_count + 1'b1;
                            end
                            res_valid = 1'b1;
                            res_data  = r_byte;
                            res_ack   = r_skip;
                            n_skip    = 1'b0;
                        end else if (!r_bad_hex && r_count < i_decode_limit) begin
                            if (!hx.ok) begin
                                n_bad_hex = 1'b1;
                            end else if (!r_half) begin
                                n_nib  = hx.nib;
                                n_half = 1'b1;
                            end else begin
                                n_half    = 1'b0;
                                n_count   = r_count + 1'b1;
                                res_valid = 1'b1;
                                res_data  = {r_nib, hx.nib};
                                res_ack   = r_skip;
                                n_skip    = 1'b0;
                            end
                        end
                    end
                end
                PH_SUMHI: begin
                    n_sum_hi = hx.nib;
                    if (!hx.ok) begin
                        n_sum_bad = 1'b1;
                    end
                    n_phase = PH_SUMLO;
                end
                PH_SUMLO: begin
                    res_valid = 1'b1;
                    res_ack   = r_skip || good;
                    n_skip    = 1'b0;
                    res_cnt   = r_count;
                    res_last  = 1'b1;
                    n_phase   = PH_IDLE;
                    priority if (!good) begin
                        res_ev = rsp_pkg::EV_BAD_SUM;
                    end else if (r_err) begin
                        res_ev = rsp_pkg::EV_ERR_REPLY;
                    end else if (i_decode_hex && r_bad_hex) begin
                        res_ev = rsp_pkg::EV_BAD_HEX;
                    end else if (i_decode_hex && r_half) begin
                        res_ev = rsp_pkg::EV_ODD_HEX;
                    end else begin
                        res_ev = rsp_pkg::EV_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_retries   <= '0;
            r_sum       <= '0;
            r_sum_hi    <= '0;
            r_sum_bad   <= 1'b0;
            r_nib       <= '0;
            r_half      <= 1'b0;
            r_count     <= '0;
            r_first     <= 1'b0;
            r_err       <= 1'b0;
            r_bad_hex   <= 1'b0;
            r_skip      <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= step && res_valid;
            end
            if (step) begin
                r_phase   <= n_phase;
                r_retries <= n_retries;
                r_sum     <= n_sum;
                r_sum_hi  <= n_sum_hi;
                r_sum_bad <= n_sum_bad;
                r_nib     <= n_nib;
                r_half    <= n_half;
                r_count   <= n_count;
                r_first   <= n_first;
                r_err     <= n_err;
                r_bad_hex <= n_bad_hex;
                r_skip    <= n_skip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_byte <= i_in.rx_byte;
        end
        if (step) begin
            r_ev      <= res_ev;
            r_data    <= res_data;
            r_ack     <= res_ack;
            r_cnt_out <= res_cnt;
            r_last    <= res_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_res  = r_ev;
    assign o_out.data_byte  = r_data;
    assign o_out.send_ack   = r_ack;
    assign o_out.byte_count = r_cnt_out;
    assign o_out.last       = r_last;

endmodule

### hw/rtl/rsp_reply_receiver.sv
// ----------------------------------------------------------------------------
// rsp_reply_receiver
// Reply receiver: acknowledgement wait, packet framing, checksum and optional
// hex decoding of the reply payload.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake               Word
//  i_in      in   valid/ready             kind, rx_byte
//  o_out     out  valid/ready             event_res, data_byte, send_ack,
//                                         byte_count, last
//  APB       in   psel/penable/pwrite     retry_limit, decode_hex, decode_limit
//
// A word is held in the input register until the result register can take
// it, and its result is then loaded into the result register; one word can
// be accepted every cycle while the result side does not stall.
// A stalled result register holds the input register, and the input side
// stalls only when both are full. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module rsp_reply_receiver #(
    parameter int COUNT_WIDTH = rsp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rsp_in_if.sink                         i_in,
    rsp_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rsp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rsp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rsp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [2:0]             retry_limit;
    logic                   decode_hex;
    logic [COUNT_WIDTH-1:0] decode_limit;

    rsp_apb_regs #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_retry_limit  (retry_limit),
        .o_decode_hex   (decode_hex),
        .o_decode_limit (decode_limit)
    );

    rsp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_retry_limit  (retry_limit),
        .i_decode_hex   (decode_hex),
        .i_decode_limit (decode_limit),
        .i_in           (i_in),
        .o_out          (o_out)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command and link words into the reply receiver, predicts every
// reply event from a behavioral copy of the receiver, and compares each
// event word field by field. Random idling on both channels, one long
// receiver hold-off, and register settings changed between phases.
// ----------------------------------------------------------------------------
package reply_check_pkg;
    import rsp_pkg::*;

    typedef struct packed {
        logic [2:0]  ev;
        logic [7:0]  data;
        logic        ack;
        logic [11:0] count;
        logic        last;
    } reply_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ACK, ST_HUNT, ST_BODY, ST_SUM_HI, ST_SUM_LO
    } link_state_t;

    class reply_scoreboard;
        logic [2:0]  retry_limit;
        logic        decode_hex;
        logic [11:0] decode_limit;

        link_state_t st;
        logic [2:0]  retries;
        logic [7:0]  sum;
        logic [3:0]  sum_hi;
        logic        sum_digit_bad;
        logic [3:0]  nib;
        logic        nib_pending;
        logic [11:0] emitted;
        logic        first_seen;
        logic        err_reply;
        logic        bad_hex;
        logic        skipped;

        reply_t      pending_replies[$];
        int unsigned mismatches;

        function new();
            retry_limit  = RETRY_LIMIT_RST;
            decode_hex   = 1'b0;
            decode_limit = 12'hfff;
            st           = ST_IDLE;
            retries      = 3'd0;
            mismatches   = 0;
            clear_exchange();
        endfunction

        function void clear_exchange();
            sum = 8'd0;
            sum_hi = 4'd0;
            sum_digit_bad = 1'b0;
            nib = 4'd0;
            nib_pending = 1'b0;
            emitted = 12'd0;
            first_seen = 1'b0;
            err_reply = 1'b0;
            bad_hex = 1'b0;
            skipped = 1'b0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_RETRY_LIMIT:  retry_limit = value[2:0];
                REG_DECODE_HEX:   decode_hex = value[0];
                REG_DECODE_LIMIT: decode_limit = value[11:0];
                default: ;
            endcase
        endfunction

        function int hex_nibble(logic [7:0] b);
            if (b >= "0" && b <= "9") return int'(b) - 48;
            if (b >= "a" && b <= "f") return int'(b) - 87;
            if (b >= "A" && b <= "F") return int'(b) - 55;
            return -1;
        endfunction

        // The owed '+' from skipped bytes rides on the first event after '$'.
        function logic take_skip();
            logic owed;
            owed = skipped;
            skipped = 1'b0;
            return owed;
        endfunction

        function void add(t_event ev, logic [7:0] data, logic ack, logic [11:0] count,
                          logic last);
            reply_t r;
            r.ev = ev;
            r.data = data;
            r.ack = ack;
            r.count = count;
            r.last = last;
            pending_replies.push_back(r);
        endfunction

        function void body_byte(logic [7:0] b);
            int v;
            sum = sum + b;
            if (!first_seen) begin
                first_seen = 1'b1;
                if (b == CH_ERR) err_reply = 1'b1;
            end
            if (!decode_hex || err_reply) begin
                if (emitted != 12'hfff) emitted = emitted + 1'b1;
                add(EV_DATA, b, take_skip(), 12'd0, 1'b0);
                return;
            end
            if (bad_hex || emitted >= decode_limit) return;
            v = hex_nibble(b);
            if (v < 0) begin
                bad_hex = 1'b1;
                return;
            end
            if (!nib_pending) begin
                nib = 4'(v);
                nib_pending = 1'b1;
                return;
            end
            nib_pending = 1'b0;
            emitted = emitted + 1'b1;
            add(EV_DATA, {nib, 4'(v)}, take_skip(), 12'd0, 1'b0);
        endfunction

        function void close_packet(logic [7:0] b);
            int     v;
            logic   good;
            logic   ack;
            t_event ev;
            v = hex_nibble(b);
            good = !sum_digit_bad && v >= 0 && ({sum_hi, 4'(v)} == sum);
            ack = take_skip();
            if (!good) ev = EV_BAD_SUM;
            else if (err_reply) ev = EV_ERR_REPLY;
            else if (decode_hex && bad_hex) ev = EV_BAD_HEX;
            else if (decode_hex && nib_pending) ev = EV_ODD_HEX;
            else ev = EV_OK;
            if (good) ack = 1'b1;
            st = ST_IDLE;
            add(ev, 8'd0, ack, emitted, 1'b1);
        endfunction

        function void note_word(logic kind, logic [7:0] b);
            int v;
            if (!kind) begin
                clear_exchange();
                retries = retry_limit;
                st = ST_ACK;
                return;
            end
            case (st)
                ST_ACK: begin
                    if (b == CH_PLUS) begin
                        clear_exchange();
                        st = ST_HUNT;
                    end else if (b == CH_MINUS && retries != 3'd0) begin
                        retries = retries - 1'b1;
                        add(EV_RESEND, 8'd0, 1'b0, 12'd0, 1'b0);
                    end else begin
                        st = ST_IDLE;
                        add(EV_ACK_MISS, 8'd0, 1'b0, 12'd0, 1'b1);
                    end
                end
                ST_HUNT: begin
                    if (b == CH_DOLLAR) st = ST_BODY;
                    else skipped = 1'b1;
                end
                ST_BODY: begin
                    if (b == CH_HASH) st = ST_SUM_HI;
                    else body_byte(b);
                end
                ST_SUM_HI: begin
                    v = hex_nibble(b);
                    if (v < 0) begin
                        sum_digit_bad = 1'b1;
                        sum_hi = 4'd0;
                    end else begin
                        sum_hi = 4'(v);
                    end
                    st = ST_SUM_LO;
                end
                ST_SUM_LO: close_packet(b);
                default: ;
            endcase
        endfunction

        function void report(string what, reply_t want, reply_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected ev=%0d data=%02h ack=%0d count=%0d last=%0d,",
                         what, want.ev, want.data, want.ack, want.count, want.last);
                $display("    got ev=%0d data=%02h ack=%0d count=%0d last=%0d",
                         got.ev, got.data, got.ack, got.count, got.last);
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0) begin
                want = '0;
                report("unexpected event word", want, got);
                return;
            end
            want = pending_replies.pop_front();
            if (got.ev !== want.ev || got.data !== want.data || got.ack !== want.ack ||
                got.count !== want.count || got.last !== want.last)
                report("event word mismatch", want, got);
        endfunction
    endclass
endpackage

module testbench;
    import rsp_pkg::*;
    import reply_check_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 6;
    localparam int N_PHASES     = 11;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } link_word_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rsp_in_if in_ch ();
    rsp_out_if #(.COUNT_WIDTH(DEF_COUNT_WIDTH)) out_ch ();

    rsp_reply_receiver #(.COUNT_WIDTH(DEF_COUNT_WIDTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    reply_scoreboard board;
    link_word_t      script[$];
    bit              steady;
    bit              hold_req;
    int unsigned     words_sent;
    int unsigned     cycles;

    int retry_set[N_PHASES] = '{0, 7, 3, 5, 1, 7, 2, 0, 6, 4, 5};
    int hex_set[N_PHASES]   = '{1, 0, 1, 1, 0, 1, 1, 0, 1, 1, 0};
    int limit_set[N_PHASES] = '{4095, 0, 3, 1, 4095, 2, 4095, 7, 4095, 0, 4095};

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        reply_t got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.ev = out_ch.event_res;
            got.data = out_ch.data_byte;
            got.ack = out_ch.send_ack;
            got.count = out_ch.byte_count;
            got.last = out_ch.last;
            board.check_reply(got);
        end
    end

    // Result side: random stalls per word, plus one long hold-off on request.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.kind = kind;
        in_ch.rx_byte = b;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_word(kind, b);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(1'b1, s[i]);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 4'd10) return 8'h30 + n;
        return (upper ? 8'h37 : 8'h57) + n;
    endfunction

    task automatic send_sum_of(input string s);
        logic [7:0] total;
        total = 8'd0;
        for (int i = 0; i < s.len(); i++) total = total + s[i];
        send_word(1'b1, hex_char(total[7:4], 1'b1));
        send_word(1'b1, hex_char(total[3:0], 1'b0));
    endtask

    // Lets the block empty out: no word offered, every event seen, and the
    // pipeline given time to finish words that cause no event.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (board.pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(idx, value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(input int retry, input int hex, input int limit);
        settle();
        write_reg(REG_RETRY_LIMIT, 32'(retry));
        write_reg(REG_DECODE_HEX, 32'(hex));
        write_reg(REG_DECODE_LIMIT, 32'(limit));
    endtask

    function automatic logic [7:0] byte_other_than(logic [7:0] avoid);
        logic [7:0] c;
        do c = 8'($urandom); while (c == avoid);
        return c;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do c = 8'($urandom); while (board.hex_nibble(c) >= 0);
        return c;
    endfunction

    function automatic void push_link(logic [7:0] b);
        link_word_t w;
        w.kind = 1'b1;
        w.value = b;
        script.push_back(w);
    endfunction

    // One exchange: command, acknowledgement, optional noise, packet and
    // checksum. Mostly well formed; a few are cut short or carry faults.
    function automatic void build_exchange(int max_len);
        link_word_t w;
        int         roll;
        int         minus_n;
        int         len;
        int         cut;
        bit         hexmode;
        logic [7:0] total;
        logic [7:0] c;
        w.kind = 1'b0;
        w.value = 8'($urandom);
        script.push_back(w);
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            push_link(8'($urandom));
            return;
        end
        minus_n = (roll < 5) ? $urandom_range(0, int'(board.retry_limit) + 1) : 0;
        for (int i = 0; i < minus_n; i++) push_link(CH_MINUS);
        if (minus_n > int'(board.retry_limit)) return;
        push_link(CH_PLUS);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) push_link(byte_other_than(CH_DOLLAR));
        push_link(CH_DOLLAR);
        cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 3) : 0;
        hexmode = board.decode_hex && $urandom_range(0, 7) != 0;
        len = $urandom_range(0, max_len);
        if (hexmode && $urandom_range(0, 3) != 0) len = len & ~1;
        total = 8'd0;
        for (int i = 0; i < len; i++) begin
            if (i == 0 && $urandom_range(0, 7) == 0) c = CH_ERR;
            else if (hexmode && $urandom_range(0, 29) != 0)
                c = hex_char(4'($urandom), 1'($urandom));
            else c = byte_other_than(CH_HASH);
            total = total + c;
            push_link(c);
        end
        if (cut == 1) return;
        push_link(CH_HASH);
        if (cut == 2) return;
        roll = $urandom_range(0, 9);
        if (roll == 0) total = total + 8'($urandom_range(1, 255));
        push_link(roll == 1 ? non_hex_byte() : hex_char(total[7:4], 1'($urandom)));
        if (cut == 3) return;
        push_link(roll == 2 ? non_hex_byte() : hex_char(total[3:0], 1'($urandom)));
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) push_link(8'($urandom));
    endfunction

    task automatic send_script();
        while (script.size() != 0) begin
            link_word_t w;
            w = script.pop_front();
            send_word(w.kind, w.value);
        end
    endtask

    initial begin
        logic [7:0]  total;
        logic [7:0]  c;
        int unsigned phase_end;
        board = new();
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.rx_byte = 8'd0;
        steady = 1'b0;
        hold_req = 1'b0;
        words_sent = 0;
        cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a byte while idle is ignored; a resend, skipped bytes
        // whose owed '+' rides on the first data word, an error reply, and
        // a command that drops an exchange before a stray answer byte.
        send_word(1'b1, 8'hff);
        send_word(1'b0, 8'h00);
        send_text("-+x$OK#");
        send_sum_of("OK");
        send_word(1'b0, 8'hff);
        send_text("+$E1#");
        send_sum_of("E1");
        send_word(1'b0, 8'h5a);
        send_text("+$");
        send_word(1'b0, 8'ha5);
        send_text("q");

        for (int p = 0; p < N_PHASES; p++) begin
            configure(retry_set[p], hex_set[p], limit_set[p]);
            if (p == 1) hold_req = 1'b1;
            phase_end = words_sent + 85;
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 7) == 0) steady = !steady;
                build_exchange(($urandom_range(0, 9) == 0) ? 40 : 12);
                send_script();
            end
        end

        // One longer raw payload to close the run.
        configure(5, 0, 4095);
        steady = 1'b0;
        send_word(1'b0, 8'h00);
        send_text("+$");
        total = 8'd0;
        for (int i = 0; i < 60; i++) begin
            c = byte_other_than(CH_HASH);
            total = total + c;
            send_word(1'b1, c);
        end
        send_word(1'b1, CH_HASH);
        send_word(1'b1, hex_char(total[7:4], 1'b0));
        send_word(1'b1, hex_char(total[3:0], 1'b1));

        settle();
        if (board.mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_if.sv
hw/rtl/rsp_apb_regs.sv
hw/rtl/rsp_core.sv
hw/rtl/rsp_reply_receiver.sv
tb/testbench.sv
